@@ sv/hbdr_pkg.sv @@
// Shared constants, operation codes and control/status types for the beacon decoder.
package hbdr_pkg;

  localparam int BEACON_BYTES = 21;
  localparam logic [4:0] LAST_POS = 5'(BEACON_BYTES - 1);
  localparam int POS_W = 5;
  localparam int DIV_DW = 36;
  localparam int DIV_SW = 24;

  localparam logic [2:0] OP_IDX = 3'd0;
  localparam logic [2:0] OP_CH  = 3'd1;
  localparam logic [2:0] OP_CLC = 3'd2;
  localparam logic [2:0] OP_SF  = 3'd3;
  localparam logic [2:0] OP_SFM = 3'd4;

  localparam logic CFG_CHANNEL_COUNT = 1'b0;
  localparam logic CFG_SCRAMBLE_COUNT = 1'b1;

  typedef struct packed {
    logic             capture;
    logic [POS_W-1:0] pos;
    logic             last;
    logic             mul;
    logic             xcmp;
    logic             div_start;
    logic [2:0]       div_op;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    logic zero;
    logic ge;
    logic tge;
    logic div_done;
    logic out_busy;
    logic out_full;
  } sts_t;

endpackage

@@ sv/hbdr_div.sv @@
// Restoring divider, one quotient bit per cycle.
module hbdr_div import hbdr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_DW-1:0] dividend,
  input  logic [DIV_SW-1:0] divisor,
  output logic              done,
  output logic [DIV_DW-1:0] quot,
  output logic [DIV_SW-1:0] rmd
);

  logic              busy_r;
  logic              done_r;
  logic [5:0]        cnt_r;
  logic [DIV_DW-1:0] work_r;
  logic [DIV_SW-1:0] rem_r;
  logic [DIV_SW-1:0] dvs_r;
  logic [DIV_SW:0]   trial;
  logic              qbit;
  logic [DIV_SW:0]   diff;

  always_comb begin
    trial = {rem_r, work_r[DIV_DW-1]};
    qbit  = (trial >= {1'b0, dvs_r});
    diff  = trial - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(DIV_DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work_r <= dividend;
      rem_r  <= '0;
      dvs_r  <= divisor;
    end else if (busy_r) begin
      work_r <= {work_r[DIV_DW-2:0], qbit};
      rem_r  <= qbit ? diff[DIV_SW-1:0] : trial[DIV_SW-1:0];
    end
  end

  assign done = done_r;
  assign quot = work_r;
  assign rmd  = rem_r;

endmodule

@@ sv/hbdr_datapath.sv @@
// Beacon byte store, timing arithmetic, configuration and result register.
module hbdr_datapath import hbdr_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  cmd_t          cmd,
  output sts_t          sts,
  input  logic [7:0]    in_byte,
  input  logic [31:0]   in_elapsed,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [8:0]    cfg_wdata,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [167:0]  out_tdata
);

  logic [7:0]  bytes_r [BEACON_BYTES];
  logic [8:0]  chans_cfg_r;
  logic [7:0]  scr_cfg_r;
  logic [32:0] t_r;
  logic signed [34:0] prod_r;
  logic [23:0] clen_r;
  logic [15:0] bound_r;
  logic [8:0]  chans_r;
  logic        zero_r;
  logic        ge_r;
  logic        tge_r;
  logic [35:0] diff_r;
  logic [35:0] idx_r;
  logic [35:0] q1_r;
  logic [35:0] sfsum_r;
  logic [7:0]  ch_o_r;
  logic [15:0] sf_o_r;
  logic [15:0] rem_o_r;
  logic [15:0] clc_o_r;
  logic        out_valid_r;
  logic [167:0] out_data_r;

  logic [7:0]  b_ch;
  logic [15:0] b_sf, b_rem, b_clc, b_delay, b_len;
  logic [7:0]  b_cnt;
  logic [8:0]  chans_eff;
  logic [7:0]  scr_eff;
  logic signed [17:0] fac;
  logic signed [35:0] x_val;
  logic [DIV_DW-1:0] dvd;
  logic [DIV_SW-1:0] dvs;
  logic        div_done;
  logic [DIV_DW-1:0] quot;
  logic [DIV_SW-1:0] rmd;

  always_comb begin
    b_ch    = bytes_r[1];
    b_sf    = {bytes_r[3], bytes_r[4]};
    b_rem   = {bytes_r[5], bytes_r[6]};
    b_clc   = {bytes_r[7], bytes_r[8]};
    b_delay = {bytes_r[16], bytes_r[17]};
    b_len   = {bytes_r[18], bytes_r[19]};
    b_cnt   = bytes_r[20];
    if (chans_cfg_r == 9'd0) begin
      chans_eff = 9'd1;
    end else if (chans_cfg_r > 9'd256) begin
      chans_eff = 9'd256;
    end else begin
      chans_eff = chans_cfg_r;
    end
    scr_eff = (scr_cfg_r == 8'd0) ? 8'd1 : scr_cfg_r;
    fac     = $signed({10'd0, b_cnt}) - 18'sd1 - $signed({2'd0, b_sf});
    x_val   = $signed({20'd0, b_rem}) + 36'(prod_r);
  end

  // select divider operands for the operation being launched
  always_comb begin
    case (cmd.div_op)
      OP_IDX: begin
        dvd = diff_r;
        dvs = clen_r;
      end
      OP_CH: begin
        dvd = idx_r;
        dvs = {15'd0, chans_r};
      end
      OP_CLC: begin
        dvd = {20'd0, b_clc} + q1_r;
        dvs = {8'd0, bound_r};
      end
      OP_SF: begin
        dvd = {3'd0, t_r - {17'd0, b_rem}};
        dvs = {8'd0, b_len};
      end
      OP_SFM: begin
        dvd = sfsum_r;
        dvs = {16'd0, b_cnt};
      end
      default: begin
        dvd = '0;
        dvs = 24'd1;
      end
    endcase
  end

  hbdr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quot     (quot),
    .rmd      (rmd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chans_cfg_r <= 9'd50;
      scr_cfg_r   <= 8'd20;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CHANNEL_COUNT:  chans_cfg_r <= cfg_wdata;
        CFG_SCRAMBLE_COUNT: scr_cfg_r   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      bytes_r[cmd.pos] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture && cmd.last) begin
      t_r <= {1'b0, in_elapsed} + {17'd0, b_delay};
    end
    if (cmd.mul) begin
      prod_r  <= fac * $signed({1'b0, b_len});
      clen_r  <= b_cnt * b_len;
      bound_r <= {7'd0, chans_eff} * {8'd0, scr_eff};
      chans_r <= chans_eff;
      zero_r  <= (b_len == 16'd0) || (b_cnt == 8'd0);
    end
    if (cmd.xcmp) begin
      ge_r    <= $signed({3'd0, t_r}) >= x_val;
      diff_r  <= 36'({3'd0, t_r} - 36'(x_val));
      tge_r   <= t_r >= {17'd0, b_rem};
      idx_r   <= {28'd0, b_ch};
      sfsum_r <= {20'd0, b_sf};
      ch_o_r  <= b_ch;
      sf_o_r  <= b_sf;
      clc_o_r <= b_clc;
      if (!zero_r && (t_r < {17'd0, b_rem})) begin
        rem_o_r <= b_rem - t_r[15:0];
      end else begin
        rem_o_r <= b_rem;
      end
    end
    if (div_done) begin
      case (cmd.div_op)
        OP_IDX: idx_r <= {28'd0, b_ch} + quot + 36'd1;
        OP_CH: begin
          q1_r   <= quot;
          ch_o_r <= rmd[7:0];
        end
        OP_CLC: clc_o_r <= rmd[15:0];
        OP_SF: begin
          sfsum_r <= {20'd0, b_sf} + quot + 36'd1;
          rem_o_r <= b_len - rmd[15:0];
        end
        OP_SFM: sf_o_r <= rmd[15:0];
        default: ;
      endcase
    end
    if (cmd.out_load) begin
      out_data_r <= {b_cnt, b_len, b_delay,
                     bytes_r[12], bytes_r[13], bytes_r[14], bytes_r[15],
                     bytes_r[10], bytes_r[11], bytes_r[9], clc_o_r,
                     rem_o_r, sf_o_r, bytes_r[2], ch_o_r, bytes_r[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    sts.zero     = zero_r;
    sts.ge       = ge_r;
    sts.tge      = tge_r;
    sts.div_done = div_done;
    sts.out_busy = out_valid_r && !out_tready;
    sts.out_full = out_valid_r;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ sv/hbdr_ctrl.sv @@
// Sequencer: byte collection, timing steps and divider launches.
module hbdr_ctrl import hbdr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  input  logic in_tuser,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_COL  = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_XC   = 3'd2;
  localparam logic [2:0] S_SEL  = 3'd3;
  localparam logic [2:0] S_GO   = 3'd4;
  localparam logic [2:0] S_WAIT = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]       st_r, st_nxt;
  logic [2:0]       op_r, op_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] pos;
  logic             accept;

  always_comb begin
    pos = in_tuser ? '0 : pos_r;
    if (pos > LAST_POS) begin
      pos = '0;
    end
    accept = in_tvalid && (st_r == S_COL);
  end

  always_comb begin
    st_nxt  = st_r;
    op_nxt  = op_r;
    pos_nxt = pos_r;
    cmd     = '0;
    cmd.pos    = pos;
    cmd.last   = (pos == LAST_POS);
    cmd.div_op = op_r;
    case (st_r)
      S_COL: begin
        if (accept) begin
          cmd.capture = 1'b1;
          if (pos == LAST_POS) begin
            pos_nxt = '0;
            st_nxt  = S_MUL;
          end else begin
            pos_nxt = pos + 5'd1;
          end
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        st_nxt  = S_XC;
      end
      S_XC: begin
        cmd.xcmp = 1'b1;
        st_nxt   = S_SEL;
      end
      S_SEL: begin
        if (sts.zero) begin
          st_nxt = S_OUT;
        end else begin
          op_nxt = sts.ge ? OP_IDX : OP_CH;
          st_nxt = S_GO;
        end
      end
      S_GO: begin
        cmd.div_start = 1'b1;
        st_nxt        = S_WAIT;
      end
      S_WAIT: begin
        if (sts.div_done) begin
          st_nxt = S_GO;
          case (op_r)
            OP_IDX: op_nxt = OP_CH;
            OP_CH:  op_nxt = OP_CLC;
            OP_CLC: op_nxt = sts.tge ? OP_SF : OP_SFM;
            OP_SF:  op_nxt = OP_SFM;
            default: st_nxt = S_OUT;
          endcase
        end
      end
      S_OUT: begin
        // hold until the result register frees up
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          st_nxt       = S_COL;
        end
      end
      default: st_nxt = S_COL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_COL;
      op_r  <= OP_IDX;
      pos_r <= '0;
    end else begin
      st_r  <= st_nxt;
      op_r  <= op_nxt;
      pos_r <= pos_nxt;
    end
  end

  assign in_tready = (st_r == S_COL);

`ifndef SYNTHESIS
  a_go_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_GO) |=> (st_r == S_WAIT)) else $error("divider launch not followed by wait");
  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (st_r == S_WAIT)) else $error("divider finished outside wait");
  a_last_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && pos == LAST_POS) |=> (st_r == S_MUL)) else $error("final byte did not start decode");
  a_load_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> sts.out_full) else $error("result load lost");
`endif

endmodule

@@ sv/hop_beacon_decode_resync.sv @@
// Latency: after a beacon's final byte come the multiply, compare and select steps; the result is
// then loaded when the superframe length or count is zero, otherwise after 3 to 5 divisions.
// Throughput: one byte per cycle while collecting; the shared one-bit-per-cycle divider
// sets the per-beacon decode time, during which no byte is taken.
// Reset: synchronous active-low rst_n clears byte position, sequencer and result valid, and
// restores channel_count to 50 and scramble_table_count to 20.
module hop_beacon_decode_resync import hbdr_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,   // beacon_byte[7:0], elapsed_slots[39:8]
  input  logic         in_tuser,   // frame_start
  output logic         out_tvalid,
  input  logic         out_tready,
  // start_delimiter, hop_channel, unicast_channel, superframe, slots_left,
  // list_counter, hops, slot_counts, since_last_beacon, proc_delay,
  // sf_length, superframes_per_channel (lowest bits first)
  output logic [167:0] out_tdata,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [8:0]   cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  hbdr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  hbdr_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_byte    (in_tdata[7:0]),
    .in_elapsed (in_tdata[39:8]),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
